@@ rtl/hpde_pkg.sv @@
// Package: shared types and saturating arithmetic for the Hermite evaluator.
package hpde_pkg;

  localparam int DEG_W = 5;
  localparam int X_W   = 20;
  localparam int V_W   = 64;
  localparam int W_W   = 72;

  localparam logic signed [W_W-1:0] POS_LIM = 72'sh00_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [W_W-1:0] NEG_LIM = -72'sh00_8000_0000_0000_0000;
  localparam logic signed [V_W-1:0] ONE_Q16 = 64'sh1_0000;

  typedef struct packed {
    logic signed [V_W-1:0] v;
    logic                  s;
  } sat_t;

  // lane 0: H, lane 1: H', lane 2: H'', lane 3: H'''
  typedef struct packed {
    logic                        vld;
    logic [DEG_W-1:0]            deg;
    logic signed [X_W-1:0]       x;
    logic [3:0][V_W-1:0]         prv;
    logic [3:0][V_W-1:0]         cur;
    logic                        sat;
  } hpde_state_t;

  function automatic sat_t sat64(input logic signed [W_W-1:0] w);
    sat_t r;
    if (w > POS_LIM) begin
      r.v = POS_LIM[V_W-1:0];
      r.s = 1'b1;
    end else if (w < NEG_LIM) begin
      r.v = NEG_LIM[V_W-1:0];
      r.s = 1'b1;
    end else begin
      r.v = w[V_W-1:0];
      r.s = 1'b0;
    end
    return r;
  endfunction

  function automatic logic signed [W_W-1:0] ext(input logic signed [V_W-1:0] a);
    return $signed({{(W_W-V_W){a[V_W-1]}}, a});
  endfunction

  function automatic sat_t sat_add(input logic signed [V_W-1:0] a,
                                   input logic signed [V_W-1:0] b);
    return sat64(ext(a) + ext(b));
  endfunction

  function automatic sat_t sat_sub(input logic signed [V_W-1:0] a,
                                   input logic signed [V_W-1:0] b);
    return sat64(ext(a) - ext(b));
  endfunction

  function automatic sat_t sat_mulk(input logic signed [V_W-1:0] a,
                                    input logic [6:0] k);
    logic signed [W_W-1:0] w;
    w = ext(a) * $signed({{(W_W-7){1'b0}}, k});
    return sat64(w);
  endfunction

endpackage

@@ rtl/hpde_if.sv @@
// Interfaces: input and result channels of the Hermite evaluator.
interface hpde_in_if;
  logic              valid;
  logic              ready;
  logic [3:0]        degree;
  logic signed [19:0] x_value;
  modport source(output valid, degree, x_value, input ready);
  modport sink(input valid, degree, x_value, output ready);
endinterface

interface hpde_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] value;
  logic signed [63:0] first_deriv;
  logic signed [63:0] second_deriv;
  logic signed [63:0] third_deriv;
  logic               saturated;
  modport source(output valid, value, first_deriv, second_deriv, third_deriv,
                 saturated, input ready);
  modport sink(input valid, value, first_deriv, second_deriv, third_deriv,
               saturated, output ready);
endinterface

@@ rtl/hpde_step.sv @@
// One recurrence step of degree N as a three-stage pipeline.
module hpde_step
  import hpde_pkg::*;
#(
  parameter int N = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  hpde_state_t st_in,
  output hpde_state_t st_out
);

  localparam logic [DEG_W-1:0] STEP = DEG_W'(N);
  localparam logic [6:0]       K    = 7'(N - 1);
  localparam logic [6:0]       K2   = 7'(2 * (N - 1));

  typedef struct packed {
    hpde_state_t          st;
    logic [3:0][44:0]     pl;
    logic [3:0][43:0]     ph;
    logic [3:0][36:0]     pf;
  } s1_t;

  typedef struct packed {
    hpde_state_t          st;
    logic [3:0][V_W-1:0]  mx;
    logic [3:1][V_W-1:0]  ta;
    logic [3:0][V_W-1:0]  tc;
    logic                 f;
  } s2_t;

  s1_t s1, s1_next;
  s2_t s2, s2_next;
  hpde_state_t st_next;

  sat_t [3:0] m_p, m_x, c_k;
  sat_t [3:1] a_c, s_a, s_b, s_m;
  sat_t       h_m, h_s;
  logic signed [W_W-1:0] pw [4];
  logic signed [W_W-1:0] fw [4];
  logic signed [V_W-1:0] hi [4];

  always_comb begin
    s1_next.st = st_in;
    for (int j = 0; j < 4; j++) begin
      hi[j] = $signed(st_in.cur[j]) >>> 16;
      s1_next.pl[j] = st_in.x * $signed({1'b0, hi[j][23:0]});
      s1_next.ph[j] = st_in.x * $signed(hi[j][47:24]);
      s1_next.pf[j] = st_in.x * $signed({1'b0, st_in.cur[j][15:0]});
    end
  end

  always_comb begin
    s2_next.st = s1.st;
    s2_next.f  = 1'b0;
    for (int j = 0; j < 4; j++) begin
      pw[j] = ($signed({{28{s1.ph[j][43]}}, s1.ph[j]}) <<< 24)
            + $signed({{27{s1.pl[j][44]}}, s1.pl[j]});
      fw[j] = ($signed({{35{s1.pf[j][36]}}, s1.pf[j]}) + 72'sd32768) >>> 16;
      m_p[j] = sat64(pw[j]);
      m_x[j] = sat_add(m_p[j].v, fw[j][V_W-1:0]);
      c_k[j] = sat_mulk(s1.st.prv[j], (j == 0) ? K2 : K);
      s2_next.mx[j] = m_x[j].v;
      s2_next.tc[j] = c_k[j].v;
      s2_next.f = s2_next.f | m_p[j].s | m_x[j].s | c_k[j].s;
    end
    for (int j = 1; j < 4; j++) begin
      a_c[j] = sat_mulk(s1.st.cur[j-1], 7'(j));
      s2_next.ta[j] = a_c[j].v;
      s2_next.f = s2_next.f | a_c[j].s;
    end
  end

  always_comb begin
    st_next = s2.st;
    h_m = sat_mulk(s2.mx[0], 7'd2);
    h_s = sat_sub(h_m.v, s2.tc[0]);
    for (int j = 1; j < 4; j++) begin
      s_a[j] = sat_add(s2.ta[j], s2.mx[j]);
      s_b[j] = sat_sub(s_a[j].v, s2.tc[j]);
      s_m[j] = sat_mulk(s_b[j].v, 7'd2);
    end
    if (s2.st.deg >= STEP) begin
      st_next.prv = s2.st.cur;
      st_next.cur = {s_m[3].v, s_m[2].v, s_m[1].v, h_s.v};
      st_next.sat = s2.st.sat | s2.f | h_m.s | h_s.s
                  | s_a[1].s | s_b[1].s | s_m[1].s
                  | s_a[2].s | s_b[2].s | s_m[2].s
                  | s_a[3].s | s_b[3].s | s_m[3].s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.st.vld <= 1'b0;
      s2.st.vld <= 1'b0;
      st_out.vld <= 1'b0;
    end else if (en) begin
      s1 <= s1_next;
      s2 <= s2_next;
      st_out <= st_next;
    end
  end

endmodule

@@ rtl/hermite_poly_derivs_eval.sv @@
// Hermite H_n(x) with first three derivatives: a fully pipelined evaluator that
// takes one transfer per cycle while the result is not stalled; each recurrence
// step has three register stages (multiply, round/scale, combine).
module hermite_poly_derivs_eval
  import hpde_pkg::*;
#(
  parameter int MAX_DEGREE = 15
) (
  input  logic            clk,
  input  logic            rst,
  hpde_in_if.sink         sample,
  hpde_out_if.source      result
);

  localparam logic [DEG_W-1:0] DMAX = DEG_W'(MAX_DEGREE);

  hpde_state_t chain [1:MAX_DEGREE];
  hpde_state_t seed;
  hpde_state_t fin;
  logic        en;
  logic [DEG_W-1:0] deg_in;

  assign en = result.ready || !result.valid;
  assign sample.ready = en;
  assign deg_in = {1'b0, sample.degree};

  always_comb begin
    seed.vld = sample.valid;
    seed.deg = (deg_in > DMAX) ? DMAX : deg_in;
    seed.x   = sample.x_value;
    seed.prv = {64'd0, 64'd0, 64'd0, ONE_Q16};
    seed.cur = {64'd0, 64'd0, 64'sd2 * ONE_Q16,
                $signed({{(V_W-X_W){sample.x_value[X_W-1]}}, sample.x_value}) <<< 1};
    seed.sat = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) chain[1].vld <= 1'b0;
    else if (en) chain[1] <= seed;
  end

  for (genvar n = 2; n <= MAX_DEGREE; n++) begin : g_step
    hpde_step #(.N(n)) u_step (
      .clk(clk), .rst(rst), .en(en), .st_in(chain[n-1]), .st_out(chain[n])
    );
  end

  assign fin = chain[MAX_DEGREE];

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid        <= fin.vld;
      result.value        <= (fin.deg == '0) ? fin.prv[0] : fin.cur[0];
      result.first_deriv  <= (fin.deg == '0) ? fin.prv[1] : fin.cur[1];
      result.second_deriv <= (fin.deg == '0) ? fin.prv[2] : fin.cur[2];
      result.third_deriv  <= (fin.deg == '0) ? fin.prv[3] : fin.cur[3];
      result.saturated    <= fin.sat;
    end
  end

endmodule

@@ rtl/hpde_checker.sv @@
// Checker: port-level properties of the Hermite evaluator, bound to the top.
module hpde_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] value
);

  a_ready_rule: assert property (@(posedge clk) disable iff (rst)
    in_ready == (out_ready || !out_valid))
    else $error("ready does not follow output stall");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(value))
    else $error("result changed while stalled");

endmodule

bind hermite_poly_derivs_eval hpde_checker u_hpde_checker (
  .clk(clk), .rst(rst),
  .in_valid(sample.valid), .in_ready(sample.ready),
  .out_valid(result.valid), .out_ready(result.ready),
  .value(result.value)
);
